// ===== rtl/core/derc_pkg.sv =====
// Shared types, constants and helpers for the dual echo range change detector.
package derc_pkg;

    localparam int BEARING_COUNT = 5;
    localparam int ADDR_W        = 5;
    localparam int DATA_W        = 32;

    // Register indexes, taken from paddr[4:2]
    localparam logic [2:0] REG_TOL      = 3'd0;
    localparam logic [2:0] REG_BEARING0 = 3'd1;
    localparam logic [2:0] REG_BEARING1 = 3'd2;
    localparam logic [2:0] REG_BEARING2 = 3'd3;
    localparam logic [2:0] REG_BEARING3 = 3'd4;
    localparam logic [2:0] REG_BEARING4 = 3'd5;

    // Change codes
    localparam logic [2:0] CHG_NONE    = 3'd0;
    localparam logic [2:0] CHG_LOST    = 3'd1;
    localparam logic [2:0] CHG_APPEAR  = 3'd2;
    localparam logic [2:0] CHG_FARTHER = 3'd3;
    localparam logic [2:0] CHG_NEARER  = 3'd4;

    localparam logic [7:0]  TOL_RESET   = 8'd51;
    localparam logic [7:0]  ANGLE_RESET = 8'd95;
    localparam logic [BEARING_COUNT-1:0][7:0] BEARING_RESET =
        {8'd140, 8'd115, 8'd95, 8'd75, 8'd50};

    localparam logic [15:0] ECHO_VALID_MIN = 16'd600;
    localparam logic [11:0] NO_READING     = 12'hFFF;

    // us / 58 == (us >> 1) / 29; 72316 / 2^21 is exact for 15-bit operands
    localparam logic [31:0] DIV29_RECIP = 32'd72316;
    localparam int          DIV29_SHIFT = 21;

    typedef struct packed {
        logic [7:0]                         tolerance;
        logic [BEARING_COUNT-1:0][7:0]      bearing;
        logic                               clear_store;
    } t_cfg;

    function automatic logic [10:0] echo_to_cm(input logic [15:0] us);
        logic [31:0] prod;
        prod = 32'(us[15:1]) * DIV29_RECIP;
        return prod[DIV29_SHIFT+10:DIV29_SHIFT];
    endfunction

endpackage

// ===== rtl/core/derc_if.sv =====
// Valid/ready channel interfaces for measurement items and results.
interface derc_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  slot;
    logic [15:0] right_echo_us;
    logic [15:0] left_echo_us;

    modport source (output valid, slot, right_echo_us, left_echo_us, input ready);
    modport sink   (input valid, slot, right_echo_us, left_echo_us, output ready);
endinterface

interface derc_out_if;
    logic              valid;
    logic              ready;
    logic [2:0]        slot_out;
    logic signed [11:0] distance_cm;
    logic [2:0]        change_code;
    logic              servo_move;
    logic [7:0]        servo_angle;

    modport source (output valid, slot_out, distance_cm, change_code, servo_move,
                    servo_angle, input ready);
    modport sink   (input valid, slot_out, distance_cm, change_code, servo_move,
                    servo_angle, output ready);
endinterface

// ===== rtl/core/derc_cfg_regs.sv =====
// APB-style register file: tolerance and bearing registers.
module derc_cfg_regs
    import derc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [7:0]                    r_tol;
    logic [BEARING_COUNT-1:0][7:0] r_bearing;
    logic                          wr_en;
    logic [2:0]                    reg_idx;
    logic                          clear_req;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol     <= TOL_RESET;
            r_bearing <= BEARING_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_TOL:      r_tol        <= pwdata[7:0];
                REG_BEARING0: r_bearing[0] <= pwdata[7:0];
                REG_BEARING1: r_bearing[1] <= pwdata[7:0];
                REG_BEARING2: r_bearing[2] <= pwdata[7:0];
                REG_BEARING3: r_bearing[3] <= pwdata[7:0];
                REG_BEARING4: r_bearing[4] <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_TOL:      prdata = DATA_W'(r_tol);
            REG_BEARING0: prdata = DATA_W'(r_bearing[0]);
            REG_BEARING1: prdata = DATA_W'(r_bearing[1]);
            REG_BEARING2: prdata = DATA_W'(r_bearing[2]);
            REG_BEARING3: prdata = DATA_W'(r_bearing[3]);
            REG_BEARING4: prdata = DATA_W'(r_bearing[4]);
            default:      prdata = '0;
        endcase
    end

    // Any bearing write invalidates every stored distance
    always_comb begin
        clear_req = 1'b0;
        if (wr_en) begin
            case (reg_idx) inside
                REG_BEARING0, REG_BEARING1, REG_BEARING2, REG_BEARING3, REG_BEARING4:
                    clear_req = 1'b1;
                default: clear_req = 1'b0;
            endcase
        end
    end

    assign o_cfg.clear_store = clear_req;
    assign o_cfg.tolerance   = r_tol;
    assign o_cfg.bearing     = r_bearing;

endmodule

// ===== rtl/core/dual_echo_range_change_detector_core.sv =====
// Top level of the dual echo range change detector.
// Usage:
//   i_in carries one measurement per transfer: a bearing slot and the right and
//   left echo widths in microseconds. o_res returns exactly one result per
//   measurement, in order: slot, new distance in cm (-1 for no reading), change
//   code, servo move flag and servo angle. The APB port holds the tolerance and
//   the five bearings; write it only while no measurement is in flight.
// Timing:
//   Three register stages in order: input, range, result. One measurement is
//   taken every cycle while o_res.ready stays high; the rate is set by the
//   per-slot read-modify-write of the distance store in the result stage,
//   which completes within that stage.
// Reset:
//   i_rst_n clears all stage valids, restores the register defaults, marks every
//   slot as having no reading and sets the current servo angle to 95 degrees.
// Back-pressure:
//   When o_res.ready is low the result register holds; earlier stages keep
//   filling until all three are full, then i_in.ready drops.
module dual_echo_range_change_detector_core
    import derc_pkg::*;
#(
    parameter int NUM_SLOTS = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    derc_in_if.sink           i_in,
    derc_out_if.source        o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // Slots that can hold a distance: limited by both the store and the bearings
    localparam int NUM_LIVE = (NUM_SLOTS < BEARING_COUNT) ? NUM_SLOTS : BEARING_COUNT;
    localparam int IDX_W    = (NUM_LIVE > 1) ? $clog2(NUM_LIVE) : 1;

    t_cfg cfg;

    derc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // ---------------------------------------------------------------
    // Stage handshake: each stage loads when it is empty or draining
    // ---------------------------------------------------------------
    logic r_v0, r_v1, r_v2;
    logic load1, load2, in_xfer;

    assign load2      = r_v1 && (!r_v2 || o_res.ready);
    assign load1      = r_v0 && (!r_v1 || load2);
    assign i_in.ready = !r_v0 || load1;
    assign in_xfer    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (in_xfer)           r_v0 <= 1'b1;
            else if (load1)        r_v0 <= 1'b0;
            if (load1)             r_v1 <= 1'b1;
            else if (load2)        r_v1 <= 1'b0;
            if (load2)             r_v2 <= 1'b1;
            else if (o_res.ready)  r_v2 <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Stage 0: input register
    // ---------------------------------------------------------------
    logic [2:0]  r0_slot;
    logic [15:0] r0_right;
    logic [15:0] r0_left;

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r0_slot  <= i_in.slot;
            r0_right <= i_in.right_echo_us;
            r0_left  <= i_in.left_echo_us;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: pick the echo and convert it to centimetres
    // ---------------------------------------------------------------
    logic        right_ok, left_ok, have_echo;
    logic [15:0] use_us;
    logic [2:0]  r1_slot;
    logic        r1_have;
    logic [10:0] r1_dist;

    assign right_ok  = r0_right >= ECHO_VALID_MIN;
    assign left_ok   = r0_left  >= ECHO_VALID_MIN;
    assign have_echo = right_ok || left_ok;

    // Take the shorter echo when both are valid; on a tie keep the right one
    always_comb begin
        if (right_ok && left_ok)
            use_us = (r0_left < r0_right) ? r0_left : r0_right;
        else if (right_ok)
            use_us = r0_right;
        else
            use_us = r0_left;
    end

    always_ff @(posedge i_clk) begin
        if (load1) begin
            r1_slot <= r0_slot;
            r1_have <= have_echo;
            r1_dist <= echo_to_cm(use_us);
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: compare with the stored distance, update the store
    // ---------------------------------------------------------------
    logic [10:0]   r_store [NUM_LIVE];
    logic [NUM_LIVE-1:0] r_known;
    logic [7:0]    r_angle;

    logic          in_range;
    logic [IDX_W-1:0] idx;
    logic [10:0]   prev_d;
    logic          prev_known;
    logic [7:0]    slot_bearing;
    logic [8:0]    tol_hi, tol_lo;
    logic [19:0]   scaled_new, bound_hi, bound_lo;
    logic [2:0]    n_code;
    logic [11:0]   n_dist;
    logic          n_move;
    logic [7:0]    n_angle;

    assign in_range     = r1_slot < 3'(NUM_LIVE);
    assign idx          = r1_slot[IDX_W-1:0];
    assign prev_d       = r_store[idx];
    assign prev_known   = r_known[idx];
    assign slot_bearing = cfg.bearing[r1_slot];

    // Exact relative test: 256*new against (256 +/- tol) * old
    assign tol_hi     = 9'd256 + {1'b0, cfg.tolerance};
    assign tol_lo     = 9'd256 - {1'b0, cfg.tolerance};
    assign scaled_new = {1'b0, r1_dist, 8'd0};
    assign bound_hi   = 20'(tol_hi) * 20'(prev_d);
    assign bound_lo   = 20'(tol_lo) * 20'(prev_d);

    always_comb begin
        n_code  = CHG_NONE;
        n_dist  = NO_READING;
        n_move  = 1'b0;
        n_angle = r_angle;
        if (in_range) begin
            n_angle = slot_bearing;
            n_move  = r_angle != slot_bearing;
            if (!r1_have) begin
                n_code = prev_known ? CHG_LOST : CHG_NONE;
            end else begin
                n_dist = {1'b0, r1_dist};
                if (!prev_known)
                    n_code = CHG_APPEAR;
                else if (scaled_new > bound_hi)
                    n_code = CHG_FARTHER;
                else if (scaled_new < bound_lo)
                    n_code = CHG_NEARER;
                else
                    n_code = CHG_NONE;
            end
        end
    end

    // Distance store: valid bits clear at reset and on any bearing write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg.clear_store) begin
            r_known <= '0;
        end else if (load2 && in_range) begin
            r_known[idx] <= r1_have;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load2 && in_range && r1_have)
            r_store[idx] <= r1_dist;
    end

    // Servo follows the bearing of the last in-range slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_angle <= ANGLE_RESET;
        else if (load2 && in_range)
            r_angle <= slot_bearing;
    end

    // Result register
    logic [2:0]  r2_slot;
    logic [11:0] r2_dist;
    logic [2:0]  r2_code;
    logic        r2_move;
    logic [7:0]  r2_angle;

    always_ff @(posedge i_clk) begin
        if (load2) begin
            r2_slot  <= r1_slot;
            r2_dist  <= n_dist;
            r2_code  <= n_code;
            r2_move  <= n_move;
            r2_angle <= n_angle;
        end
    end

    assign o_res.valid       = r_v2;
    assign o_res.slot_out    = r2_slot;
    assign o_res.distance_cm = $signed(r2_dist);
    assign o_res.change_code = r2_code;
    assign o_res.servo_move  = r2_move;
    assign o_res.servo_angle = r2_angle;

endmodule

// ===== verif/derc_range_check_pkg.sv =====
// Scoreboard for the range change detector: predicts each result and checks the block's output.
package derc_range_check_pkg;
    import derc_pkg::*;

    localparam int US_PER_CM = 58;
    localparam int TOL_ONE   = 256;

    typedef struct packed {
        logic [2:0]  slot;
        logic [15:0] right_echo_us;
        logic [15:0] left_echo_us;
    } meas_t;

    typedef struct packed {
        logic [2:0]         slot_out;
        logic signed [11:0] distance_cm;
        logic [2:0]         change_code;
        logic               servo_move;
        logic [7:0]         servo_angle;
    } range_result_t;

    class range_scoreboard;
        int unsigned        num_slots;
        logic [7:0]         tolerance;
        logic [7:0]         bearing [BEARING_COUNT];
        logic signed [11:0] stored_cm [BEARING_COUNT];
        logic [7:0]         angle_now;
        range_result_t      expected_q [$];
        int unsigned        errors;

        function new(int unsigned slots);
            num_slots = slots;
            tolerance = TOL_RESET;
            for (int i = 0; i < BEARING_COUNT; i++) begin
                bearing[i]   = BEARING_RESET[i];
                stored_cm[i] = NO_READING;
            end
            angle_now = ANGLE_RESET;
            errors    = 0;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10) begin
                $display("%s", msg);
            end
        endfunction

        // Mirror a register write; any bearing write wipes the distance store
        function void apply_reg(logic [2:0] idx, logic [31:0] value);
            if (idx == REG_TOL) begin
                tolerance = value[7:0];
            end else if (idx >= REG_BEARING0 && idx <= REG_BEARING4) begin
                bearing[idx - REG_BEARING0] = value[7:0];
                for (int i = 0; i < BEARING_COUNT; i++) begin
                    stored_cm[i] = NO_READING;
                end
            end
        endfunction

        function int stored(int s);
            if (s >= 0 && s < BEARING_COUNT) begin
                return stored_cm[s];
            end
            return -1;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_measurement(meas_t m);
            range_result_t e;
            logic          r_ok;
            logic          l_ok;
            logic [15:0]   pick_us;
            int            d;
            int            dist_cm;
            int            t;
            e.slot_out    = m.slot;
            e.distance_cm = NO_READING;
            e.change_code = CHG_NONE;
            e.servo_move  = 1'b0;
            e.servo_angle = angle_now;
            if (m.slot < num_slots && m.slot < BEARING_COUNT) begin
                d             = stored_cm[m.slot];
                e.servo_angle = bearing[m.slot];
                e.servo_move  = (angle_now != e.servo_angle);
                angle_now     = e.servo_angle;
                r_ok = m.right_echo_us >= ECHO_VALID_MIN;
                l_ok = m.left_echo_us >= ECHO_VALID_MIN;
                if (!r_ok && !l_ok) begin
                    if (d != -1) begin
                        e.change_code = CHG_LOST;
                    end
                end else begin
                    if (r_ok && l_ok) begin
                        pick_us = (m.left_echo_us < m.right_echo_us) ? m.left_echo_us
                                                                     : m.right_echo_us;
                    end else begin
                        pick_us = r_ok ? m.right_echo_us : m.left_echo_us;
                    end
                    dist_cm       = int'(pick_us) / US_PER_CM;
                    t             = int'(tolerance);
                    e.distance_cm = dist_cm[11:0];
                    if (d == -1) begin
                        e.change_code = CHG_APPEAR;
                    end else if (TOL_ONE * dist_cm > (TOL_ONE + t) * d) begin
                        e.change_code = CHG_FARTHER;
                    end else if (TOL_ONE * dist_cm < (TOL_ONE - t) * d) begin
                        e.change_code = CHG_NEARER;
                    end
                end
                stored_cm[m.slot] = e.distance_cm;
            end
            expected_q.push_back(e);
        endfunction

        function void check_result(range_result_t got);
            range_result_t e;
            logic          bad;
            if (expected_q.size() == 0) begin
                flag($sformatf("result with nothing expected: slot %0d dist %0d code %0d",
                               got.slot_out, got.distance_cm, got.change_code));
                return;
            end
            e   = expected_q.pop_front();
            bad = (got.slot_out !== e.slot_out) || (got.distance_cm !== e.distance_cm)
                || (got.change_code !== e.change_code) || (got.servo_move !== e.servo_move)
                || (got.servo_angle !== e.servo_angle);
            if (bad) begin
                flag($sformatf({"mismatch: exp slot %0d dist %0d code %0d move %0b angle %0d",
                                " / got slot %0d dist %0d code %0d move %0b angle %0d"},
                               e.slot_out, e.distance_cm, e.change_code, e.servo_move,
                               e.servo_angle, got.slot_out, got.distance_cm,
                               got.change_code, got.servo_move, got.servo_angle));
            end
        endfunction

        function void finish_check();
            if (expected_q.size() != 0) begin
                flag($sformatf("%0d results never arrived", expected_q.size()));
            end
        endfunction
    endclass

endpackage

// ===== verif/dual_echo_range_change_detector_core_test.sv =====
// Testbench for the dual echo range change detector core: directed and random measurements.
module dual_echo_range_change_detector_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import derc_pkg::*;
    import derc_range_check_pkg::*;

    localparam int NUM_SLOTS   = 5;
    localparam int QUIET_LIMIT = 3000;   // cycles with no transfer of any kind
    localparam int PHASE_ITEMS = 150;
    localparam int PHASES      = 6;
    localparam int SETTLE      = 4;      // wait after the last result before register writes
    localparam logic [2:0] REG_SPARE = REG_BEARING4 + 3'd1;  // beyond the register list

    typedef struct {
        logic [2:0]  idx;
        logic [31:0] value;
    } reg_write_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    derc_in_if  in_bus ();
    derc_out_if res_bus ();

    range_scoreboard sb;
    reg_write_t      write_list [$];
    bit              calm_mode;
    int              quiet_cycles;

    always #10ns i_clk = ~i_clk;

    dual_echo_range_change_detector_core #(
        .NUM_SLOTS (NUM_SLOTS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_res   (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Gap length for either side: mostly none, some short, a few long.
    // Calm phases drop all idling so the pipeline runs back to back.
    function automatic int pick_gap();
        int roll;
        if (calm_mode) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 65) begin
            return 0;
        end else if (roll < 88) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // Echo width: timeouts, short echoes, values around the validity threshold,
    // the full range, and most often a width close to the slot's stored distance
    // so that the tolerance test is hit on both sides.
    function automatic logic [15:0] pick_echo(input int prev_cm);
        int roll;
        int span;
        int cm;
        int us;
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            return 16'd0;
        end else if (roll < 15) begin
            return 16'($urandom_range(1, 599));
        end else if (roll < 21) begin
            return 16'($urandom_range(590, 620));
        end else if (roll < 40 || prev_cm < 0) begin
            return 16'($urandom_range(0, 65535));
        end
        span = prev_cm / 3 + 2;
        cm   = prev_cm + int'($urandom_range(0, 2 * span)) - span;
        if (cm < 10) begin
            cm = 10;
        end
        if (cm > 1129) begin
            cm = 1129;
        end
        us = cm * US_PER_CM + int'($urandom_range(0, US_PER_CM - 1));
        if (us > 65535) begin
            us = 65535;
        end
        return 16'(us);
    endfunction

    function automatic logic [7:0] pick_bearing();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            return 8'($urandom_range(181, 255));
        end else if (roll < 15) begin
            return 8'd0;
        end else if (roll < 20) begin
            return 8'd180;
        end
        return 8'($urandom_range(0, 180));
    endfunction

    // Queue a register write; the upper data bits carry noise the block must ignore
    function automatic void queue_write(input logic [2:0] idx, input logic [7:0] value);
        reg_write_t w;
        w.idx   = idx;
        w.value = $urandom;
        w.value[7:0] = value;
        write_list.push_back(w);
    endfunction

    // Hold one measurement on the input channel until it is taken. Valid stays
    // high between back-to-back items so it never drops and rises in one step.
    task automatic send_measurement(input logic [2:0] slot, input logic [15:0] right_us,
                                    input logic [15:0] left_us);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid         <= 1'b1;
        in_bus.slot          <= slot;
        in_bus.right_echo_us <= right_us;
        in_bus.left_echo_us  <= left_us;
        do @(posedge i_clk); while (in_bus.ready !== 1'b1);
    endtask

    task automatic send_random();
        logic [2:0]  slot;
        logic [15:0] right_us;
        logic [15:0] left_us;
        int          prev_cm;
        // Mostly live slots; the rest span all codes, the unused ones included
        slot     = ($urandom_range(0, 99) < 90) ? 3'($urandom_range(0, 4))
                                                : 3'($urandom_range(0, 7));
        prev_cm  = sb.stored(int'(slot));
        right_us = pick_echo(prev_cm);
        left_us  = ($urandom_range(0, 19) == 0) ? right_us : pick_echo(prev_cm);
        send_measurement(slot, right_us, left_us);
    endtask

    // Drop valid, let every expected result come back, then allow the
    // pipeline to settle before anything touches the registers.
    task automatic drain();
        in_bus.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Issue the queued writes back to back: setup then access for each, and
    // release the bus in the step of the final access.
    task automatic flush_writes();
        reg_write_t w;
        while (write_list.size() != 0) begin
            w        = write_list.pop_front();
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {w.idx, 2'b00};
            pwdata  <= w.value;
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (pready !== 1'b1);
            sb.apply_reg(w.idx, w.value);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Result side: random stretches of back-pressure between bursts of ready.
    initial begin : result_sink
        int hold;
        int run;
        res_bus.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            hold = pick_gap();
            if (hold > 0) begin
                res_bus.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            res_bus.ready <= 1'b1;
            run = $urandom_range(1, 16);
            repeat (run) @(posedge i_clk);
        end
    end

    // Monitor both channels at the clock edge: check each result against the
    // oldest prediction, predict each accepted measurement, and run the watchdog.
    always @(posedge i_clk) begin : monitor
        bit            moved;
        range_result_t got;
        meas_t         m;
        if (i_rst_n !== 1'b1) begin
            quiet_cycles <= 0;
        end else begin
            moved = 1'b0;
            if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
                got.slot_out    = res_bus.slot_out;
                got.distance_cm = res_bus.distance_cm;
                got.change_code = res_bus.change_code;
                got.servo_move  = res_bus.servo_move;
                got.servo_angle = res_bus.servo_angle;
                sb.check_result(got);
                moved = 1'b1;
            end
            if (in_bus.valid === 1'b1 && in_bus.ready === 1'b1) begin
                m.slot          = in_bus.slot;
                m.right_echo_us = in_bus.right_echo_us;
                m.left_echo_us  = in_bus.left_echo_us;
                sb.note_measurement(m);
                moved = 1'b1;
            end
            if (psel && penable && pwrite && pready) begin
                moved = 1'b1;
            end
            if (moved) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        sb        = new(NUM_SLOTS);
        calm_mode = 1'b0;

        // Drive every input to a known value while reset is held
        i_rst_n              <= 1'b0;
        in_bus.valid         <= 1'b0;
        in_bus.slot          <= '0;
        in_bus.right_echo_us <= '0;
        in_bus.left_echo_us  <= '0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: no reading on an empty slot, a single valid echo,
        // timeouts on both sides, equal echoes, farther, nearer and lost
        send_measurement(3'd2, 16'd0, 16'd0);
        send_measurement(3'd2, 16'd600, 16'd0);
        send_measurement(3'd2, 16'd599, 16'hFFFF);
        send_measurement(3'd2, 16'hFFFF, 16'hFFFF);
        send_measurement(3'd2, 16'd0, 16'd0);
        send_measurement(3'd0, 16'd5800, 16'd5800);
        send_measurement(3'd0, 16'd6960, 16'd0);
        send_measurement(3'd0, 16'd4640, 16'd9999);
        send_measurement(3'd1, 16'd599, 16'd599);
        send_measurement(3'd1, 16'd600, 16'd601);
        send_measurement(3'd1, 16'd602, 16'd601);
        send_measurement(3'd3, 16'd30000, 16'd1000);
        send_measurement(3'd4, 16'h8000, 16'h7FFF);
        // Slot codes beyond the store leave all state alone
        send_measurement(3'd5, 16'd1234, 16'd4321);
        send_measurement(3'd7, 16'hFFFF, 16'd0);
        send_measurement(3'd6, 16'd0, 16'd0);
        drain();

        // Zero tolerance: any step either way counts
        queue_write(REG_TOL, 8'd0);
        flush_writes();
        send_measurement(3'd0, 16'd4640, 16'd4640);
        send_measurement(3'd0, 16'd4698, 16'd0);
        send_measurement(3'd0, 16'd0, 16'd4640);
        drain();

        // Widest tolerance
        queue_write(REG_TOL, 8'hFF);
        flush_writes();
        send_measurement(3'd0, 16'd600, 16'd0);
        send_measurement(3'd0, 16'hFFFF, 16'd0);
        drain();

        // Bearing extremes, one above the servo range; the store is cleared
        queue_write(REG_BEARING0, 8'd0);
        queue_write(REG_BEARING1, 8'd180);
        queue_write(REG_BEARING2, 8'd180);
        queue_write(REG_BEARING3, 8'd0);
        queue_write(REG_BEARING4, 8'hFF);
        flush_writes();
        send_measurement(3'd0, 16'd3000, 16'd0);
        send_measurement(3'd4, 16'd0, 16'd3000);
        send_measurement(3'd2, 16'd700, 16'd800);
        send_measurement(3'd1, 16'd900, 16'd900);
        drain();

        // Random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++) begin
            calm_mode = (p == 1 || p == 4);
            case (p)
                0: begin
                    queue_write(REG_TOL, 8'd0);
                    for (int b = 0; b < BEARING_COUNT; b++) begin
                        queue_write(REG_BEARING0 + 3'(b), pick_bearing());
                    end
                end
                1: begin
                    queue_write(REG_TOL, 8'hFF);
                    queue_write(REG_BEARING2, pick_bearing());
                end
                2: begin : same_bearing
                    logic [7:0] shared;
                    // Every slot at one angle: after the first in-range item the servo need not move
                    shared = pick_bearing();
                    queue_write(REG_TOL, 8'($urandom_range(0, 255)));
                    for (int b = 0; b < BEARING_COUNT; b++) begin
                        queue_write(REG_BEARING0 + 3'(b), shared);
                    end
                end
                3: begin
                    queue_write(REG_TOL, TOL_RESET);
                    for (int b = 0; b < BEARING_COUNT; b++) begin
                        queue_write(REG_BEARING0 + 3'(b), BEARING_RESET[b]);
                    end
                end
                4: begin
                    queue_write(REG_TOL, 8'($urandom_range(1, 254)));
                    queue_write(REG_BEARING1, pick_bearing());
                    queue_write(REG_BEARING3, pick_bearing());
                end
                default: begin
                    // Tolerance only, so the store survives; plus a write past the list
                    queue_write(REG_SPARE, 8'($urandom_range(0, 255)));
                    queue_write(REG_TOL, 8'($urandom_range(0, 255)));
                end
            endcase
            flush_writes();
            repeat (PHASE_ITEMS) send_random();
            drain();
        end

        // Allow stray results to show up before the verdict
        repeat (10) @(posedge i_clk);
        sb.finish_check();
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== dual_echo_range_change_detector_core.f =====
rtl/core/derc_pkg.sv
rtl/core/derc_if.sv
rtl/core/derc_cfg_regs.sv
rtl/core/dual_echo_range_change_detector_core.sv
verif/derc_range_check_pkg.sv
verif/dual_echo_range_change_detector_core_test.sv
